[sv/srtf_pkg.sv]
package srtf_pkg;

    localparam int NumCoresDefault  = 4;
    localparam int QueueDepthDefault = 16;

    // Input transaction payload.
    typedef struct packed {
        logic        func;
        logic [7:0]  proc_id;
        logic [15:0] burst_time;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic        kind;
        logic        queue_full;
        logic [1:0]  core_index;
        logic        core_busy;
        logic [7:0]  run_proc_id;
        logic [15:0] remaining_after;
        logic        completed;
        logic [31:0] finish_time;
        logic        last;
    } out_item_t;

    // One ready-store entry as it travels along the chain.
    typedef struct packed {
        logic        valid;
        logic [7:0]  proc;
        logic [15:0] remaining;
    } entry_t;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

endpackage

[sv/srtf_cell.sv]
module srtf_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  srtf_pkg::entry_t din,
    output srtf_pkg::entry_t dout
);
    import srtf_pkg::*;

    logic        valid_reg;
    logic [7:0]  proc_reg;
    logic [15:0] rem_reg;

    // The valid bit is control state and clears at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= din.valid;
        end
    end

    // Payload takes the neighbor's entry on every shift.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            proc_reg <= din.proc;
            rem_reg  <= din.remaining;
        end
    end

    assign dout = '{valid: valid_reg, proc: proc_reg, remaining: rem_reg};

endmodule

[sv/multicore_srtf_scheduler.sv]
// Preemptive shortest-remaining-time-first scheduler over several cores.
// The input channel (in_valid, in_stall, in_data) takes one transaction at a
// time: an arrival puts a process into the ready store, a tick runs one
// scheduling pass. Results leave on (out_valid, out_stall, out_data): one
// acknowledgement per arrival, one report per active core per tick, with
// last set on the final one. The cfg channel writes active_cores (reset 4).
// The ready store is a ring of cells that rotates one slot per cycle during a
// pass over it. An arrival scans the ring for a free slot and, if one is found,
// runs a second pass to write the process there; when the store is full nothing
// is written. Either way the acknowledgement follows. A tick does, per active
// core, a pass for the minimum search, a second pass to take or swap an entry
// when the store is not empty, and then the report. in_stall stays high until the
// last result of the current transaction has been loaded into the output
// register. When the receiver stalls, the output register holds its result
// and the scheduler waits before producing the next one. Reset empties the
// store and all cores, clears the time to zero and needs no clearing pass.
module multicore_srtf_scheduler #(
    parameter int NUM_CORES   = srtf_pkg::NumCoresDefault,
    parameter int QUEUE_DEPTH = srtf_pkg::QueueDepthDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  srtf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output srtf_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_data
);
    import srtf_pkg::*;

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam logic [SW-1:0] LastSlot = SW'(QUEUE_DEPTH - 1);
    localparam logic [4:0]    MaxCores = 5'(NUM_CORES);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ASCAN  = 7'b0000010,
        ST_AWRITE = 7'b0000100,
        ST_AACK   = 7'b0001000,
        ST_TSCAN  = 7'b0010000,
        ST_TUPD   = 7'b0100000,
        ST_TCORE  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [SW-1:0]   k_reg, k_next;
    logic [CW-1:0]   c_reg, c_next;
    logic            found_reg, found_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [15:0]     best_reg, best_next;
    logic [7:0]      arr_proc_reg;
    logic [15:0]     arr_burst_reg;
    logic [2:0]      active_reg;
    logic [31:0]     time_reg, time_next;
    logic            out_valid_reg;
    out_item_t       out_reg;

    logic            core_valid_reg [NUM_CORES];
    logic [7:0]      core_proc_reg  [NUM_CORES];
    logic [15:0]     core_rem_reg   [NUM_CORES];

    entry_t          cell_q [QUEUE_DEPTH];
    entry_t          feedback;
    logic            shift;
    logic            load_ok;
    logic            accept;
    logic [4:0]      n_eff;
    logic            last_core;
    logic            cur_valid;
    logic [15:0]     cur_rem;
    logic [15:0]     dec_rem;
    logic            core_take;
    logic            core_swap;
    logic [SW-1:0]   k_step;
    out_item_t       result;
    logic            emit;

    // Ready store: a ring of cells, cell 0 is read, the last cell is written.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t din;
        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign din = feedback;
        end
        else
        begin : g_link
            assign din = cell_q[i+1];
        end
        srtf_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .din   (din),
            .dout  (cell_q[i])
        );
    end

    assign shift   = (state_reg == ST_ASCAN) || (state_reg == ST_AWRITE) ||
                     (state_reg == ST_TSCAN) || (state_reg == ST_TUPD);
    assign load_ok = !out_valid_reg || !out_stall;
    assign accept  = in_valid && (state_reg == ST_IDLE);

    // Slot counter follows the ring and wraps after the last slot.
    assign k_step  = (k_reg == LastSlot) ? '0 : k_reg + SW'(1);

    // Effective number of active cores after clamping.
    always_comb
    begin
        n_eff = (active_reg == 3'd0) ? 5'd1 : 5'(active_reg);
        if (n_eff > MaxCores)
        begin
            n_eff = MaxCores;
        end
    end

    assign last_core = (5'(c_reg) == (n_eff - 5'd1));
    assign cur_valid = core_valid_reg[c_reg];
    assign cur_rem   = core_rem_reg[c_reg];
    assign dec_rem   = cur_rem - 16'd1;
    assign core_take = (state_reg == ST_TUPD) && (k_reg == slot_reg) && !cur_valid;
    assign core_swap = (state_reg == ST_TUPD) && (k_reg == slot_reg) && cur_valid &&
                       (cur_rem > cell_q[0].remaining);

    // Entry fed back into the ring, replaced at the chosen slot.
    always_comb
    begin
        feedback = cell_q[0];
        if ((state_reg == ST_AWRITE) && (k_reg == slot_reg))
        begin
            feedback = '{valid: 1'b1, proc: arr_proc_reg, remaining: arr_burst_reg};
        end
        else if (core_take)
        begin
            feedback.valid = 1'b0;
        end
        else if (core_swap)
        begin
            feedback = '{valid: 1'b1, proc: core_proc_reg[c_reg], remaining: cur_rem};
        end
    end

    // Result of the current step.
    always_comb
    begin
        result = '0;
        if (state_reg == ST_AACK)
        begin
            result.kind       = KIND_ACK;
            result.queue_full = !found_reg;
            result.last       = 1'b1;
        end
        else
        begin
            result.kind        = KIND_REPORT;
            result.core_index  = 2'(c_reg);
            result.finish_time = time_reg;
            result.last        = last_core;
            if (cur_valid)
            begin
                result.core_busy       = 1'b1;
                result.run_proc_id     = core_proc_reg[c_reg];
                result.remaining_after = dec_rem;
                result.completed       = (dec_rem == 16'd0);
            end
        end
    end

    assign emit = ((state_reg == ST_AACK) || (state_reg == ST_TCORE)) && load_ok;

    // Sequencer for scans, updates and reports.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        found_next = found_reg;
        slot_next  = slot_reg;
        best_next  = best_reg;
        time_next  = time_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next     = '0;
                c_next     = '0;
                found_next = 1'b0;
                if (in_valid)
                begin
                    state_next = (in_data.func == FUNC_TICK) ? ST_TSCAN : ST_ASCAN;
                end
            end
            ST_ASCAN:
            begin
                k_next = k_step;
                if (!found_reg && !cell_q[0].valid)
                begin
                    found_next = 1'b1;
                    slot_next  = k_reg;
                end
                if (k_reg == LastSlot)
                begin
                    state_next = found_next ? ST_AWRITE : ST_AACK;
                end
            end
            ST_AWRITE:
            begin
                k_next = k_step;
                if (k_reg == LastSlot)
                begin
                    state_next = ST_AACK;
                end
            end
            ST_AACK:
            begin
                if (load_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TSCAN:
            begin
                k_next = k_step;
                if (cell_q[0].valid && (!found_reg || (cell_q[0].remaining < best_reg)))
                begin
                    found_next = 1'b1;
                    slot_next  = k_reg;
                    best_next  = cell_q[0].remaining;
                end
                if (k_reg == LastSlot)
                begin
                    state_next = found_next ? ST_TUPD : ST_TCORE;
                end
            end
            ST_TUPD:
            begin
                k_next = k_step;
                if (k_reg == LastSlot)
                begin
                    state_next = ST_TCORE;
                end
            end
            ST_TCORE:
            begin
                if (load_ok)
                begin
                    found_next = 1'b0;
                    k_next     = '0;
                    if (last_core)
                    begin
                        time_next  = time_reg + 32'd1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        c_next     = c_reg + CW'(1);
                        state_next = ST_TSCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            c_reg         <= '0;
            found_reg     <= 1'b0;
            time_reg      <= '0;
            active_reg    <= 3'd4;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            found_reg <= found_next;
            time_reg  <= time_next;
            if (cfg_valid)
            begin
                active_reg <= cfg_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Core valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CORES; i++)
            begin
                core_valid_reg[i] <= 1'b0;
            end
        end
        else if (core_take)
        begin
            core_valid_reg[c_reg] <= 1'b1;
        end
        else if (emit && (state_reg == ST_TCORE) && cur_valid && (dec_rem == 16'd0))
        begin
            core_valid_reg[c_reg] <= 1'b0;
        end
    end

    // Payload registers: core contents, search results, arrival data, output.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        best_reg <= best_next;
        if (accept)
        begin
            arr_proc_reg  <= in_data.proc_id;
            arr_burst_reg <= in_data.burst_time;
        end
        if (core_take || core_swap)
        begin
            core_proc_reg[c_reg] <= cell_q[0].proc;
            core_rem_reg[c_reg]  <= cell_q[0].remaining;
        end
        else if (emit && (state_reg == ST_TCORE) && cur_valid)
        begin
            core_rem_reg[c_reg] <= dec_rem;
        end
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

[sv/srtf_checker.sv]
module srtf_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  srtf_pkg::out_item_t out_data
);
    import srtf_pkg::*;

    // A held result keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // After an accepted transaction the scheduler is busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // An acknowledgement is always the single, final result.
    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_ACK) |-> out_data.last)
        else $error("acknowledgement without last");

    // An acknowledgement carries no core report.
    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_ACK) |->
            (out_data.core_index == 2'd0) && !out_data.core_busy && !out_data.completed)
        else $error("acknowledgement carries core data");

    // Only a busy core can complete.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.completed |-> out_data.core_busy &&
            (out_data.remaining_after == 16'd0))
        else $error("completion without a running process");

endmodule

bind multicore_srtf_scheduler srtf_checker u_srtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
